// ===== hdl/linear_probe_hash_table_defines.svh =====
// Assertion macros used by the hash table top level.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// A property checked at every clock edge outside reset.
`define LPHT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must be followed by a consequence at the next clock edge.
`define LPHT_ASSERT_NEXT(name, cond, conseq, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

// ===== hdl/lpht_pkg.sv =====
// Types, codes and constants shared by the hash table modules.
package lpht_pkg;

  localparam int unsigned LPHT_CAPACITY_DEFAULT = 256;
  localparam int unsigned LPHT_HASH_W           = 32;
  localparam int unsigned LPHT_MOD_BITS         = 4;
  localparam int unsigned LPHT_MOD_STEPS        = LPHT_HASH_W / LPHT_MOD_BITS;
  localparam logic [7:0]  LPHT_MAX_USED_RESET   = 8'd192;
  localparam int unsigned LPHT_STEP_W           = 3;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key_hash;
    logic [63:0] key_word;
    logic [63:0] data_value;
  } lpht_in_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] read_value;
    logic [1:0]  status;
  } lpht_out_t;

  typedef struct packed {
    logic        status_we;
    logic        kv_we;
    slot_state_t status;
    logic [63:0] key;
    logic [63:0] value;
  } slot_wr_t;

  typedef struct packed {
    slot_state_t status;
    logic [63:0] key;
    logic [63:0] value;
  } slot_rd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MOD,
    OP_CHECK,
    OP_PROBE,
    OP_FINISH,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_FIRE,
    COND_MOD_DONE,
    COND_PRE_DONE,
    COND_PROBE_END,
    COND_OUT_FREE,
    COND_CLR_DONE
  } ucond_t;

  typedef struct packed {
    uop_t                   op;
    ucond_t                 cond;
    logic                   hold;
    logic [LPHT_STEP_W-1:0] target;
  } ucode_t;

  localparam logic [LPHT_STEP_W-1:0] STEP_CLEAR  = 3'd0;
  localparam logic [LPHT_STEP_W-1:0] STEP_IDLE   = 3'd1;
  localparam logic [LPHT_STEP_W-1:0] STEP_MOD    = 3'd2;
  localparam logic [LPHT_STEP_W-1:0] STEP_CHECK  = 3'd3;
  localparam logic [LPHT_STEP_W-1:0] STEP_PROBE  = 3'd4;
  localparam logic [LPHT_STEP_W-1:0] STEP_FINISH = 3'd5;
  localparam logic [LPHT_STEP_W-1:0] STEP_RESULT = 3'd6;

endpackage

// ===== hdl/lpht_mod.sv =====
// Start slot: hash mod capacity, 4 bits per advance, or low bits if pow2.
module lpht_mod import lpht_pkg::*; #(
  parameter int unsigned CAPACITY = LPHT_CAPACITY_DEFAULT,
  localparam int unsigned IDX_W = $clog2(CAPACITY)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [LPHT_HASH_W-1:0] hash,
  input  logic                   advance,
  output logic                   done,
  output logic [IDX_W-1:0]       rem
);

  localparam bit          POW2    = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam int unsigned CNT_W   = $clog2(LPHT_MOD_STEPS);
  localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);

  logic [LPHT_HASH_W-1:0] hash_sh;
  logic [IDX_W-1:0]       r;
  logic [IDX_W-1:0]       r_next;
  logic [CNT_W-1:0]       cnt;

  always_comb begin
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] acc;
    acc = r;
    t   = '0;
    for (int i = 0; i < LPHT_MOD_BITS; i++) begin
      t = {acc, hash_sh[LPHT_HASH_W-1-i]};
      if (t >= CAP_EXT) begin
        t = t - CAP_EXT;
      end
      acc = t[IDX_W-1:0];
    end
    r_next = acc;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hash_sh <= hash;
      r       <= '0;
    end else if (advance && !POW2) begin
      hash_sh <= hash_sh << LPHT_MOD_BITS;
      r       <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (advance) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign done = POW2 || (cnt == CNT_W'(LPHT_MOD_STEPS - 1));
  assign rem  = POW2 ? hash_sh[IDX_W-1:0] : r;

endmodule

// ===== hdl/lpht_slot_mem.sv =====
// Slot store: status, key and value memories with the clearing pass after reset.
module lpht_slot_mem import lpht_pkg::*; #(
  parameter int unsigned CAPACITY = LPHT_CAPACITY_DEFAULT,
  localparam int unsigned IDX_W = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] raddr,
  output slot_rd_t         rd,
  input  logic [IDX_W-1:0] waddr,
  input  slot_wr_t         wr,
  output logic             clear_busy
);

  slot_state_t      status_mem [CAPACITY];
  logic [63:0]      key_mem    [CAPACITY];
  logic [63:0]      value_mem  [CAPACITY];
  logic [IDX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      if (clr_addr == IDX_W'(CAPACITY - 1)) begin
        clear_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      status_mem[clr_addr] <= SLOT_EMPTY;
    end else if (wr.status_we) begin
      status_mem[waddr] <= wr.status;
    end
    rd.status <= status_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.kv_we) begin
      key_mem[waddr]   <= wr.key;
      value_mem[waddr] <= wr.value;
    end
    rd.key   <= key_mem[raddr];
    rd.value <= value_mem[raddr];
  end

endmodule

// ===== hdl/linear_probe_hash_table.sv =====
// Top level of the linear probing hash table with its microcoded sequencer.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_stall    in_item   (lpht_in_t)
//   out       output     out_valid / out_stall  out_item  (lpht_out_t)
//   cfg       input      cfg_we                 cfg_data  (max_used_slots)
//
// An item probes one slot a cycle until a match, an empty slot or the whole table;
// an insert refused by the load limit, a lookup or delete on an empty table, or an
// unknown command skips probing. A capacity that is not a power of two lengthens
// the start slot remainder step. After reset a clearing pass marks every slot empty
// and no item is accepted meanwhile. A finished result waits in the output register
// while the next item is accepted; out_stall holds it there.
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int unsigned CAPACITY = LPHT_CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  lpht_in_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output lpht_out_t  out_item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);

  function automatic ucode_t ucode_rom(input logic [LPHT_STEP_W-1:0] s);
    ucode_t w;
    case (s)
      STEP_CLEAR:  w = '{OP_NONE,   COND_CLR_DONE,  1'b1, STEP_IDLE};
      STEP_IDLE:   w = '{OP_ACCEPT, COND_IN_FIRE,   1'b1, STEP_MOD};
      STEP_MOD:    w = '{OP_MOD,    COND_MOD_DONE,  1'b1, STEP_CHECK};
      STEP_CHECK:  w = '{OP_CHECK,  COND_PRE_DONE,  1'b0, STEP_RESULT};
      STEP_PROBE:  w = '{OP_PROBE,  COND_PROBE_END, 1'b1, STEP_FINISH};
      STEP_FINISH: w = '{OP_FINISH, COND_ALWAYS,    1'b0, STEP_RESULT};
      STEP_RESULT: w = '{OP_EMIT,   COND_OUT_FREE,  1'b1, STEP_IDLE};
      default:     w = '{OP_NONE,   COND_ALWAYS,    1'b0, STEP_IDLE};
    endcase
    return w;
  endfunction

  logic [LPHT_STEP_W-1:0] step;
  logic [LPHT_STEP_W-1:0] step_next;
  ucode_t                 uw;
  logic                   cond_true;

  logic [1:0]       cmd_r;
  logic [63:0]      key_r;
  logic [63:0]      val_r;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] cur_inc;
  logic [IDX_W-1:0] probe_cnt;
  logic             tomb_valid;
  logic [IDX_W-1:0] tomb_addr;
  logic             found_match;
  logic             found_empty;
  logic [63:0]      match_value;
  lpht_out_t        res;
  logic [8:0]       used_count;
  logic [7:0]       max_used_slots;

  logic             in_fire;
  logic             out_free;
  logic             mod_done;
  logic [IDX_W-1:0] start_slot;
  logic             clear_busy;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  slot_rd_t         rd;
  slot_wr_t         wr;

  logic             ins_full;
  logic             pre_done;
  lpht_out_t        pre_res;
  logic             is_match;
  logic             is_empty;
  logic             is_tomb;
  logic             probe_end;
  lpht_out_t        fin_res;
  logic             fin_inc;

  lpht_mod #(.CAPACITY(CAPACITY)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (in_fire),
    .hash    (in_item.key_hash),
    .advance (uw.op == OP_MOD),
    .done    (mod_done),
    .rem     (start_slot)
  );

  lpht_slot_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk        (clk),
    .rst        (rst),
    .raddr      (raddr),
    .rd         (rd),
    .waddr      (waddr),
    .wr         (wr),
    .clear_busy (clear_busy)
  );

  assign uw       = ucode_rom(step);
  assign in_stall = (uw.op != OP_ACCEPT);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cur_inc  = (cur == LAST_SLOT) ? '0 : cur + 1'b1;

  always_comb begin
    case (uw.op)
      OP_CHECK: raddr = start_slot;
      OP_PROBE: raddr = cur_inc;
      default:  raddr = cur;
    endcase
  end

  // Checks made before any probing.
  always_comb begin
    ins_full = ({1'b0, used_count} + 10'd1) > {2'b00, max_used_slots};
    pre_res  = '0;
    case (cmd_r)
      CMD_INSERT: begin
        pre_done = ins_full;
        pre_res.status = ST_FULL;
      end
      CMD_LOOKUP, CMD_DELETE: begin
        pre_done = (used_count == 9'd0);
        pre_res.status = ST_EMPTY;
      end
      default: begin
        pre_done = 1'b1;
      end
    endcase
  end

  assign is_match  = (rd.status == SLOT_USED) && (rd.key == key_r);
  assign is_tomb   = (rd.status == SLOT_TOMB);
  assign is_empty  = (rd.status != SLOT_USED) && !is_tomb;
  assign probe_end = is_match || is_empty || (probe_cnt == LAST_SLOT);

  always_comb begin
    wr        = '0;
    wr.key    = key_r;
    wr.value  = val_r;
    wr.status = SLOT_USED;
    waddr     = cur;
    fin_res   = '0;
    fin_inc   = 1'b0;
    if (uw.op == OP_FINISH) begin
      case (cmd_r)
        CMD_INSERT: begin
          if (found_match) begin
            wr.kv_we = 1'b1;
          end else if (tomb_valid) begin
            waddr        = tomb_addr;
            wr.status_we = 1'b1;
            wr.kv_we     = 1'b1;
            fin_res.hit  = 1'b1;
          end else if (found_empty) begin
            wr.status_we = 1'b1;
            wr.kv_we     = 1'b1;
            fin_inc      = 1'b1;
            fin_res.hit  = 1'b1;
          end else begin
            fin_res.status = ST_FULL;
          end
        end
        CMD_LOOKUP: begin
          if (found_match) begin
            fin_res.hit        = 1'b1;
            fin_res.read_value = match_value;
          end
        end
        CMD_DELETE: begin
          if (found_match) begin
            wr.status_we = 1'b1;
            wr.status    = SLOT_TOMB;
            fin_res.hit  = 1'b1;
          end
        end
        default: begin
          fin_res = '0;
        end
      endcase
    end
  end

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_IN_FIRE:   cond_true = in_fire;
      COND_MOD_DONE:  cond_true = mod_done;
      COND_PRE_DONE:  cond_true = pre_done;
      COND_PROBE_END: cond_true = probe_end;
      COND_OUT_FREE:  cond_true = out_free;
      COND_CLR_DONE:  cond_true = !clear_busy;
      default:        cond_true = 1'b1;
    endcase
    if (cond_true) begin
      step_next = uw.target;
    end else if (uw.hold) begin
      step_next = step;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_CLEAR;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_item.command;
      key_r <= in_item.key_word;
      val_r <= in_item.data_value;
    end
    case (uw.op)
      OP_CHECK: begin
        cur         <= start_slot;
        probe_cnt   <= '0;
        tomb_valid  <= 1'b0;
        found_match <= 1'b0;
        found_empty <= 1'b0;
        res         <= pre_res;
      end
      OP_PROBE: begin
        if (is_tomb && !tomb_valid) begin
          tomb_valid <= 1'b1;
          tomb_addr  <= cur;
        end
        if (is_match) begin
          found_match <= 1'b1;
          match_value <= rd.value;
        end
        if (is_empty) begin
          found_empty <= 1'b1;
        end
        if (!probe_end) begin
          cur       <= cur_inc;
          probe_cnt <= probe_cnt + 1'b1;
        end
      end
      OP_FINISH: begin
        res <= fin_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count     <= '0;
      max_used_slots <= LPHT_MAX_USED_RESET;
    end else begin
      if (fin_inc && (used_count != 9'h1FF)) begin
        used_count <= used_count + 1'b1;
      end
      if (cfg_we) begin
        max_used_slots <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((uw.op == OP_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.op == OP_EMIT) && out_free) begin
      out_item <= res;
    end
  end

  `LPHT_ASSERT(a_no_accept_while_clearing, clear_busy |-> in_stall, "accepted while clearing")
  `LPHT_ASSERT(a_used_never_lowered, !$past(rst) |-> used_count >= $past(used_count),
               "used count lowered")
  `LPHT_ASSERT(a_write_only_in_finish, (wr.status_we || wr.kv_we) |-> step == STEP_FINISH,
               "slot write outside finish step")
  `LPHT_ASSERT_NEXT(a_emit_loads_output, (uw.op == OP_EMIT) && out_free,
                    out_valid && (step == STEP_IDLE), "result not presented")

endmodule

// ===== tb/hash_table_checker.sv =====
// Checker that predicts every reply of the hash table and compares it with the block's output.
module hash_table_checker import lpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = LPHT_CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  lpht_in_t   in_item,
  input  logic       out_valid,
  input  logic       out_stall,
  input  lpht_out_t  out_item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         replies_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NO_SLOT = -1;

  logic [63:0] slot_key [TABLE_SIZE];
  logic [63:0] slot_value [TABLE_SIZE];
  slot_state_t slot_state [TABLE_SIZE];
  int unsigned used_slots;
  logic [7:0]  load_limit;
  lpht_out_t   expected_replies [$];
  int          reply_count;

  initial begin
    mismatches = 0;
    replies_pending = 0;
    reply_count = 0;
  end

  function automatic int find_slot(input logic [31:0] hash, input logic [63:0] key,
                                   output int first_tomb, output int hole);
    int idx;
    int match;
    idx = int'(hash % TABLE_SIZE);
    first_tomb = NO_SLOT;
    hole = NO_SLOT;
    match = NO_SLOT;
    for (int n = 0; n < TABLE_SIZE && match == NO_SLOT && hole == NO_SLOT; n++) begin
      case (slot_state[idx])
        SLOT_USED: if (slot_key[idx] == key) match = idx;
        SLOT_TOMB: if (first_tomb == NO_SLOT) first_tomb = idx;
        default:   hole = idx;
      endcase
      idx = int'((idx + 1) % TABLE_SIZE);
    end
    return match;
  endfunction

  function automatic lpht_out_t apply_command(input lpht_in_t req);
    lpht_out_t reply;
    int match;
    int tomb;
    int hole;
    int target;
    reply = '{hit: 1'b0, read_value: '0, status: ST_DONE};
    case (req.command)
      CMD_INSERT: begin
        if (used_slots + 1 > load_limit) begin
          reply.status = ST_FULL;
        end else begin
          match = find_slot(req.key_hash, req.key_word, tomb, hole);
          if (match != NO_SLOT) begin
            slot_value[match] = req.data_value;
          end else begin
            target = (tomb != NO_SLOT) ? tomb : hole;
            if (target == NO_SLOT) begin
              reply.status = ST_FULL;
            end else begin
              if (tomb == NO_SLOT) used_slots++;
              slot_state[target] = SLOT_USED;
              slot_key[target] = req.key_word;
              slot_value[target] = req.data_value;
              reply.hit = 1'b1;
            end
          end
        end
      end
      CMD_LOOKUP, CMD_DELETE: begin
        if (used_slots == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          match = find_slot(req.key_hash, req.key_word, tomb, hole);
          if (match != NO_SLOT) begin
            reply.hit = 1'b1;
            if (req.command == CMD_LOOKUP) reply.read_value = slot_value[match];
            else slot_state[match] = SLOT_TOMB;
          end
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    lpht_out_t want;
    if (rst) begin
      foreach (slot_state[i]) slot_state[i] = SLOT_EMPTY;
      used_slots = 0;
      load_limit = LPHT_MAX_USED_RESET;
      expected_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        reply_count++;
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply %0d arrived with none expected", reply_count));
        end else begin
          want = expected_replies.pop_front();
          if (out_item.hit !== want.hit)
            report_mismatch($sformatf("reply %0d hit %0b, expected %0b",
                                      reply_count, out_item.hit, want.hit));
          if (out_item.read_value !== want.read_value)
            report_mismatch($sformatf("reply %0d read_value %0h, expected %0h",
                                      reply_count, out_item.read_value, want.read_value));
          if (out_item.status !== want.status)
            report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                      reply_count, out_item.status, want.status));
        end
      end
      if (cfg_we) load_limit = cfg_data;
      if (in_valid && !in_stall) expected_replies.push_back(apply_command(in_item));
    end
    replies_pending = expected_replies.size();
  end

endmodule

// ===== tb/linear_probe_hash_table_tb.sv =====
// Testbench top for the hash table: clock, reset, stimulus, receiver stalls and the verdict.
module linear_probe_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int POOL_SIZE     = 40;
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 270;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 300;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  lpht_in_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  lpht_out_t  out_item;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit long_hold = 1'b0;
  bit hold_spent = 1'b0;
  int mismatches;
  int replies_pending;

  logic [63:0] pool_key [POOL_SIZE];
  logic [31:0] pool_hash [POOL_SIZE];

  linear_probe_hash_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  hash_table_checker reply_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .replies_pending (replies_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The one long hold-off is counted here, while the sender keeps offering items.
  always @(posedge clk) begin
    if (long_hold && !hold_spent) begin
      hold_spent <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic lpht_in_t request(input logic [1:0] command, input logic [31:0] hash,
                                       input logic [63:0] key, input logic [63:0] value);
    lpht_in_t req;
    req.command = command;
    req.key_hash = hash;
    req.key_word = key;
    req.data_value = value;
    return req;
  endfunction

  function automatic lpht_in_t random_request(input int noise_pct);
    lpht_in_t req;
    int pick;
    int roll;
    pick = $urandom_range(POOL_SIZE - 1);
    roll = $urandom_range(99);
    req.data_value = {$urandom, $urandom};
    if ($urandom_range(99) < noise_pct) begin
      req.command = 2'($urandom);
      req.key_hash = $urandom;
      req.key_word = {$urandom, $urandom};
    end else begin
      req.key_hash = pool_hash[pick];
      req.key_word = pool_key[pick];
      req.command = (roll < 40) ? CMD_INSERT :
                    (roll < 75) ? CMD_LOOKUP :
                    (roll < 95) ? CMD_DELETE : CMD_UNUSED;
    end
    return req;
  endfunction

  task automatic offer(input lpht_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (replies_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] limit);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct <= 74; recv_stall_pct <= 0;  end
      IDLE_RECEIVER: begin send_idle_pct <= 0;  recv_stall_pct <= 74; end
      IDLE_BOTH:     begin send_idle_pct <= 13; recv_stall_pct <= 13; end
      default:       begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
    endcase
  endtask

  initial begin : stimulus
    logic [7:0] phase_limit [5];
    int         phase_noise [5];
    int         base;
    phase_limit = '{8'd40, 8'd8, 8'd120, 8'd200, 8'd255};
    phase_noise = '{20, 20, 25, 30, 40};
    // Keys come in pairs that differ in one bit and share a hash, clustered so
    // that probe chains grow long and wrap past the top of the table.
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 2 == 1) begin
        pool_key[i] = pool_key[i - 1] ^ (64'd1 << $urandom_range(63));
        pool_hash[i] = pool_hash[i - 1];
      end else begin
        base = (i < POOL_SIZE / 2) ? 248 : 96;
        pool_key[i] = {$urandom, $urandom};
        pool_hash[i] = ($urandom & 32'hFFFF_FF00) | 32'(8'(base + $urandom_range(11)));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    offer(request(CMD_LOOKUP, '1, '1, '0));
    offer(request(CMD_DELETE, '0, '0, '1));
    offer(request(CMD_UNUSED, '1, '1, '1));
    set_limit(8'd0);
    offer(request(CMD_INSERT, '1, '1, '1));
    set_limit(8'd1);
    offer(request(CMD_INSERT, '1, '1, '1));
    offer(request(CMD_INSERT, '1, '1, '0));
    offer(request(CMD_LOOKUP, '1, '1, '0));
    offer(request(CMD_DELETE, '1, '1, '0));
    offer(request(CMD_LOOKUP, '1, '1, '0));
    set_limit(8'd255);
    offer(request(CMD_INSERT, 32'h0000_00FF, '0, 64'h0123_4567_89AB_CDEF));
    offer(request(CMD_INSERT, '1, 64'd1, 64'hFEDC_BA98_7654_3210));
    offer(request(CMD_INSERT, '1, 64'd1, 64'h5555_AAAA_5555_AAAA));
    offer(request(CMD_LOOKUP, '1, 64'd1, '0));
    offer(request(CMD_LOOKUP, '1, 64'h8000_0000_0000_0000, '0));
    offer(request(CMD_DELETE, 32'h0000_00FF, '0, '0));
    offer(request(CMD_LOOKUP, '1, 64'd1, '1));
    offer(request(CMD_INSERT, '1, 64'd1, 64'hAAAA_5555_AAAA_5555));
    offer(request(CMD_DELETE, '1, 64'd5, '0));
    offer(request(CMD_UNUSED, '1, '1, '1));
    offer(request(CMD_INSERT, 32'h8000_0000, '1, '1));

    drain();
    set_idle(IDLE_NONE);
    long_hold <= 1'b1;
    repeat (16) offer(random_request(20));
    drain();

    for (int p = 0; p < 5; p++) begin
      set_limit(phase_limit[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) set_idle(idle_mode_t'((n / 50 + p) % 4));
        offer(random_request(phase_noise[p]));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lpht_pkg.sv
hdl/lpht_mod.sv
hdl/lpht_slot_mem.sv
hdl/linear_probe_hash_table.sv
tb/hash_table_checker.sv
tb/linear_probe_hash_table_tb.sv
